// File: rtl/core/nfpe_pkg.sv
// ----------------------------------------------------------------------------
// nfpe_pkg: shared types and constants
// Sizes of the flash array, action and status codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package nfpe_pkg;

	localparam int FLASH_BYTES = 262144;
	localparam int PAGE_BYTES  = 1024;
	localparam int WORD_COUNT  = (FLASH_BYTES + 3) / 4;
	localparam int WA_W        = $clog2(WORD_COUNT);
	localparam int OFF_W       = $clog2(FLASH_BYTES);
	localparam int CNT_W       = $clog2(WORD_COUNT + 1);

	localparam int S_TDATA_W = 88;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 40;
	localparam int PADDR_W   = 3;

	localparam logic [31:0] BASE_RESET      = 32'h0800_0000;
	localparam logic        REG_WINDOW_BASE = 1'b0;

	typedef enum logic [2:0] {
		ACT_RD_BYTE    = 3'd0,
		ACT_WR_BYTE    = 3'd1,
		ACT_RD_WORD    = 3'd2,
		ACT_WR_WORD    = 3'd3,
		ACT_PROG_WORD  = 3'd4,
		ACT_ERASE      = 3'd5,
		ACT_MASS_ERASE = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_OUTSIDE  = 2'd1,
		STS_RANGE    = 2'd2,
		STS_MISALIGN = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_RD_A,
		S_RD_B,
		S_CAPT,
		S_WR_A,
		S_WR_B,
		S_ERASE_CALC,
		S_ERASE,
		S_DONE
	} fsm_t;

endpackage

`default_nettype wire

// File: rtl/core/nfpe_ram.sv
// ----------------------------------------------------------------------------
// nfpe_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nfpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/nor_flash_program_erase_model.sv
// ----------------------------------------------------------------------------
// nor_flash_program_erase_model: NOR flash window with program and erase
// One access per request; bits only clear on write, erase sets whole pages.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on s_axis: tuser = action, tdata = address, data, length.
//    One response leaves on m_axis per request: read data and status.
//  - window_base is written through the APB port at byte address 0.
//  - One request is worked on at a time by a sequencer around a single
//    65536 x 32 RAM (one write and one read port, registered read).
//  - Byte and word accesses and word programs: decode, read both words the
//    access may touch, write back the touched words on a write, then load
//    the response; the next request is taken after that.
//  - Failed word programs and erases, zero lengths and the unused action
//    skip the RAM and go from decode straight to the response.
//  - Range erase: the span is widened to whole pages (256 words per page)
//    and the erased words are written one per cycle, then the response.
//    Mass erase walks the whole array the same way. The erase walk is set
//    by the RAM write port.
//  - Reset: a clearing pass writes all ones over the RAM, one word per cycle
//    over all 65536 words; no request is taken during it, APB writes are.
//  - A finished response waits in the output register while the next request
//    is already taken; the sequencer only stalls in its final state if the
//    output register is still full when the next response is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module nor_flash_program_erase_model (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// request: tuser = action[2:0]
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// request: address[31:0], data[63:32], length[82:64], zero pad
	input  wire logic [nfpe_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  wire logic [nfpe_pkg::S_TUSER_W-1:0] s_axis_tuser,
	// response: read_data[31:0], status[33:32], zero pad
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic      [nfpe_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [nfpe_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready
);

	import nfpe_pkg::*;

	localparam int EW = 33; // erase bound math, room for carry

	// control state
	fsm_t             state_q, state_nx;
	logic [CNT_W-1:0] sweep_q, sweep_end_q;
	logic             m_valid_q;
	logic [31:0]      base_q;

	// captured request
	action_t          act_q;
	logic [31:0]      addr_q;
	logic [31:0]      data_q;
	logic [18:0]      len_q;

	// decoded access
	logic [3:0]       mask_q;
	logic [1:0]       lane_q;
	logic [WA_W-1:0]  wa_q;
	logic [OFF_W-1:0] off_q;
	status_t          sts_q;
	logic             rd_q, wr_q;
	logic [31:0]      word_a_q, word_b_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// decoder outputs
	logic [3:0]  dec_inside;
	logic [32:0] dec_diff [4];
	logic [31:0] dec_off;
	logic [32:0] dec_len;
	logic        dec_span_ok;
	logic [3:0]  dec_mask;
	status_t     dec_sts;
	logic        dec_rd, dec_wr, dec_mass;
	fsm_t        dec_next;

	// merge / assembly
	logic [31:0] rd_word;
	logic [31:0] merged_a, merged_b;
	logic        be_a, be_b;

	// erase bounds
	logic [EW-1:0] e_off, e_len, e_first, e_last;

	// RAM side
	logic            ram_we;
	logic [WA_W-1:0] ram_waddr, ram_raddr;
	logic [31:0]     ram_wdata, ram_rdata;

	logic sweep_last, out_free, cfg_wr, res_load;

	assign sweep_last = (sweep_q + CNT_W'(1)) == sweep_end_q;
	assign out_free   = !m_valid_q || m_axis_tready;
	assign cfg_wr     = psel && penable && pwrite && (paddr[2] == REG_WINDOW_BASE);

	assign pready        = 1'b1;
	assign prdata        = (paddr[2] == REG_WINDOW_BASE) ? base_q : 32'd0;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;

	nfpe_ram #(
		.WIDTH (32),
		.DEPTH (WORD_COUNT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Decode: per-byte window test, span checks, which words get touched.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			dec_diff[i]   = {1'b0, addr_q + 32'(i)} - {1'b0, base_q};
			dec_inside[i] = !dec_diff[i][32] && (dec_diff[i] < EW'(FLASH_BYTES));
		end
		dec_off     = addr_q - base_q;
		dec_len     = EW'(len_q);
		dec_span_ok = (len_q != 19'd0) && (dec_len <= EW'(FLASH_BYTES)) &&
			!dec_diff[0][32] && (dec_diff[0] <= EW'(FLASH_BYTES) - dec_len);

		dec_mask = 4'b0000;
		dec_sts  = STS_OK;
		dec_rd   = 1'b0;
		dec_wr   = 1'b0;
		dec_mass = 1'b0;
		dec_next = S_DONE;
		unique case (act_q)
			ACT_RD_BYTE, ACT_WR_BYTE: begin
				dec_mask = {3'b000, dec_inside[0]};
				dec_sts  = dec_inside[0] ? STS_OK : STS_OUTSIDE;
				dec_rd   = (act_q == ACT_RD_BYTE);
				dec_wr   = (act_q == ACT_WR_BYTE);
				dec_next = S_RD_A;
			end
			ACT_RD_WORD, ACT_WR_WORD: begin
				dec_mask = dec_inside;
				dec_sts  = (&dec_inside) ? STS_OK : STS_OUTSIDE;
				dec_rd   = (act_q == ACT_RD_WORD);
				dec_wr   = (act_q == ACT_WR_WORD);
				dec_next = S_RD_A;
			end
			ACT_PROG_WORD: begin
				if (len_q == 19'd0) begin
					dec_sts = STS_OK;
				end else if (!dec_span_ok) begin
					dec_sts = STS_RANGE;
				end else if ((addr_q[1:0] != 2'b00) || (len_q[1:0] != 2'b00)) begin
					dec_sts = STS_MISALIGN;
				end else if (len_q != 19'd4) begin
					dec_sts = STS_RANGE;
				end else begin
					// whole word is inside; may still straddle two words
					dec_mask = 4'b1111;
					dec_wr   = 1'b1;
					dec_next = S_RD_A;
				end
			end
			ACT_ERASE: begin
				if (len_q == 19'd0) begin
					dec_sts = STS_OK;
				end else if (!dec_span_ok) begin
					dec_sts = STS_RANGE;
				end else begin
					dec_next = S_ERASE_CALC;
				end
			end
			ACT_MASS_ERASE: begin
				dec_mass = 1'b1;
				dec_next = S_ERASE;
			end
			default: begin
				dec_next = S_DONE;
			end
		endcase
	end

	// Erase bounds widened to pages, last page clipped at the array end.
	always_comb begin
		e_off   = EW'(off_q);
		e_len   = EW'(len_q);
		e_first = (e_off / PAGE_BYTES) * PAGE_BYTES;
		e_last  = ((e_off + e_len - EW'(1)) / PAGE_BYTES + EW'(1)) * PAGE_BYTES;
		if (e_last > EW'(FLASH_BYTES)) begin
			e_last = EW'(FLASH_BYTES);
		end
	end

	// Byte i of the access sits in lane (lane + i) mod 4 of word A,
	// or of word B once it wraps past lane 3.
	always_comb begin
		logic [1:0] ln;
		logic [2:0] pos;
		logic [1:0] bi;
		logic       use_a, use_b;
		rd_word  = 32'd0;
		merged_a = word_a_q;
		merged_b = word_b_q;
		be_a     = 1'b0;
		be_b     = 1'b0;
		for (int i = 0; i < 4; i++) begin
			pos = {1'b0, lane_q} + 3'(i);
			ln  = pos[1:0];
			if (mask_q[i]) begin
				rd_word[8*i +: 8] = pos[2] ? word_b_q[{ln, 3'b000} +: 8]
					: word_a_q[{ln, 3'b000} +: 8];
			end
		end
		for (int l = 0; l < 4; l++) begin
			bi    = 2'(l) - lane_q;
			use_a = mask_q[bi] && (2'(l) >= lane_q);
			use_b = mask_q[bi] && (2'(l) < lane_q);
			if (use_a) begin
				merged_a[8*l +: 8] = word_a_q[8*l +: 8] & data_q[{bi, 3'b000} +: 8];
			end
			if (use_b) begin
				merged_b[8*l +: 8] = word_b_q[8*l +: 8] & data_q[{bi, 3'b000} +: 8];
			end
			be_a = be_a | use_a;
			be_b = be_b | use_b;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR:      if (sweep_last) state_nx = S_IDLE;
			S_IDLE:       if (s_axis_tvalid) state_nx = S_DECODE;
			S_DECODE:     state_nx = dec_next;
			S_RD_A:       state_nx = S_RD_B;
			S_RD_B:       state_nx = S_CAPT;
			S_CAPT:       state_nx = S_WR_A;
			S_WR_A:       state_nx = S_WR_B;
			S_WR_B:       state_nx = S_DONE;
			S_ERASE_CALC: state_nx = S_ERASE;
			S_ERASE:      if (sweep_last) state_nx = S_DONE;
			S_DONE:       if (out_free) state_nx = S_IDLE;
			default:      state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		res_load      = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = wa_q;
		ram_wdata     = merged_a;
		ram_raddr     = wa_q;
		unique case (state_q)
			S_IDLE: s_axis_tready = 1'b1;
			S_RD_B: ram_raddr = wa_q + WA_W'(1);
			S_WR_A: ram_we = wr_q && be_a;
			S_WR_B: begin
				ram_we    = wr_q && be_b;
				ram_waddr = wa_q + WA_W'(1);
				ram_wdata = merged_b;
			end
			S_CLEAR, S_ERASE: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q[WA_W-1:0];
				ram_wdata = '1;
			end
			S_DONE: res_load = out_free;
			default: ram_we = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sweep_q     <= '0;
			sweep_end_q <= CNT_W'(WORD_COUNT);
			m_valid_q   <= 1'b0;
			base_q      <= BASE_RESET;
		end else begin
			state_q <= state_nx;
			if (cfg_wr) begin
				base_q <= pwdata;
			end
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (state_q == S_CLEAR || state_q == S_ERASE) begin
				sweep_q <= sweep_q + CNT_W'(1);
			end else if (state_q == S_ERASE_CALC) begin
				sweep_q     <= e_first[CNT_W+1:2];
				sweep_end_q <= e_last[CNT_W+1:2];
			end else if (state_q == S_DECODE && dec_mass) begin
				sweep_q     <= '0;
				sweep_end_q <= CNT_W'(WORD_COUNT);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q  <= action_t'(s_axis_tuser);
			addr_q <= s_axis_tdata[31:0];
			data_q <= s_axis_tdata[63:32];
			len_q  <= s_axis_tdata[82:64];
		end
		if (state_q == S_DECODE) begin
			mask_q <= dec_mask;
			lane_q <= dec_off[1:0];
			wa_q   <= dec_off[WA_W+1:2];
			off_q  <= dec_off[OFF_W-1:0];
			sts_q  <= dec_sts;
			rd_q   <= dec_rd;
			wr_q   <= dec_wr;
		end
		if (state_q == S_RD_B) begin
			word_a_q <= ram_rdata;
		end
		if (state_q == S_CAPT) begin
			word_b_q <= ram_rdata;
		end
		if (res_load) begin
			m_tdata_q <= {(M_TDATA_W - 34)'(0), sts_q, rd_q ? rd_word : 32'd0};
		end
	end

	// a taken request blocks the input until its response is queued
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request taken while another is in flight");

	// sweep cursor never runs past its end bound
	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR || state_q == S_ERASE) |-> (sweep_q < sweep_end_q))
		else $error("sweep cursor out of range");

	a_sweep_end_max: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_end_q <= CNT_W'(WORD_COUNT))
		else $error("sweep end beyond array");

	// store is never written in the idle, decode or done states
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE || state_q == S_DECODE) |-> !ram_we)
		else $error("store written outside an access");

endmodule

`default_nettype wire

// File: dv/nfpe_access_checker.sv
// ----------------------------------------------------------------------------
// nfpe_access_checker: flash image predictor and response comparator
// Watches the APB port and both streams. Keeps its own flash image and window
// base, predicts each request's response, and compares in order.
// ----------------------------------------------------------------------------
module nfpe_access_checker
	import nfpe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	// address[31:0], data[63:32], length[82:64], zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// action[2:0]
	input  logic [S_TUSER_W-1:0] s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// read_data[31:0], status[33:32], zero pad
	input  logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] WINDOW_BASE_ADDR = PADDR_W'(4 * REG_WINDOW_BASE);
	localparam logic [31:0]        FLASH_SPAN       = 32'(FLASH_BYTES);

	typedef struct packed {
		logic [31:0] rd;
		status_t     st;
	} reply_t;

	logic [31:0] image [WORD_COUNT];
	logic [31:0] window_base;
	reply_t      due_replies [$];
	reply_t      want;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		if (mismatches < 100)
			$display("%0t ns  %s: got %h, want %h", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	function automatic logic [7:0] byte_at(input logic [31:0] off);
		return image[off[OFF_W-1:2]][8*off[1:0] +: 8];
	endfunction

	// NOR write: bits only clear
	task automatic clear_bits(input logic [31:0] off, input logic [7:0] keep);
		image[off[OFF_W-1:2]][8*off[1:0] +: 8] = byte_at(off) & keep;
	endtask

	task automatic fill_erased(input int first_word, input int end_word);
		for (int w = first_word; w < end_word; w++)
			image[w] = '1;
	endtask

	// no wrap past the top of the address space
	function automatic bit in_window(input logic [31:0] a);
		logic [31:0] d;
		d = a - window_base;
		return (a >= window_base) && (d < FLASH_SPAN);
	endfunction

	function automatic bit span_ok(input logic [31:0] a, input logic [31:0] n);
		if (n == 32'd0 || n > FLASH_SPAN || a < window_base)
			return 1'b0;
		return (a - window_base) <= (FLASH_SPAN - n);
	endfunction

	task automatic predict_access(input logic [2:0] act, input logic [31:0] addr,
	                              input logic [31:0] data, input logic [18:0] len,
	                              output reply_t r);
		logic [31:0] n, pg, off, first, last;
		r.rd = '0;
		r.st = STS_OK;
		n    = 32'(len);
		pg   = 32'(PAGE_BYTES);
		case (act)
		ACT_RD_BYTE: begin
			if (in_window(addr)) r.rd = 32'(byte_at(addr - window_base));
			else r.st = STS_OUTSIDE;
		end
		ACT_WR_BYTE: begin
			if (in_window(addr)) clear_bits(addr - window_base, data[7:0]);
			else r.st = STS_OUTSIDE;
		end
		ACT_RD_WORD: begin
			// each byte checked alone; address wraps mod 2^32
			for (int i = 0; i < 4; i++) begin
				if (in_window(addr + 32'(i)))
					r.rd[8*i +: 8] = byte_at(addr + 32'(i) - window_base);
				else
					r.st = STS_OUTSIDE;
			end
		end
		ACT_WR_WORD: begin
			for (int i = 0; i < 4; i++) begin
				if (in_window(addr + 32'(i)))
					clear_bits(addr + 32'(i) - window_base, data[8*i +: 8]);
				else
					r.st = STS_OUTSIDE;
			end
		end
		ACT_PROG_WORD: begin
			if (n != 32'd0) begin
				if (!span_ok(addr, n)) r.st = STS_RANGE;
				else if (addr[1:0] != 2'b00 || n[1:0] != 2'b00) r.st = STS_MISALIGN;
				else if (n != 32'd4) r.st = STS_RANGE;
				else begin
					for (int i = 0; i < 4; i++)
						clear_bits(addr + 32'(i) - window_base, data[8*i +: 8]);
				end
			end
		end
		ACT_ERASE: begin
			if (n != 32'd0) begin
				if (!span_ok(addr, n)) begin
					r.st = STS_RANGE;
				end else begin
					// widen to whole pages, clip at the array end
					off   = addr - window_base;
					first = (off / pg) * pg;
					last  = ((off + n - 32'd1) / pg + 32'd1) * pg;
					if (last > FLASH_SPAN) last = FLASH_SPAN;
					fill_erased(int'(first >> 2), int'(last >> 2));
				end
			end
		end
		ACT_MASS_ERASE: fill_erased(0, WORD_COUNT);
		default: ;
		endcase
	endtask

	// config first, then the older response, then the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_erased(0, WORD_COUNT);
			window_base = BASE_RESET;
			due_replies.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == WINDOW_BASE_ADDR)
				window_base = pwdata;
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_replies.size() == 0) begin
					report("response with no request pending", m_axis_tdata[31:0], '0);
				end else begin
					want = due_replies.pop_front();
					if (m_axis_tdata[31:0] !== want.rd)
						report("read_data", m_axis_tdata[31:0], want.rd);
					if (m_axis_tdata[33:32] !== want.st)
						report("status", 32'(m_axis_tdata[33:32]), 32'(want.st));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_access(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
				               s_axis_tdata[82:64], want);
				due_replies.push_back(want);
			end
		end
		outstanding = due_replies.size();
	end

endmodule

// File: dv/nor_flash_program_erase_model_tb.sv
// ----------------------------------------------------------------------------
// nor_flash_program_erase_model_tb: stream-level test of the flash window
// Directed requests hit the window edges, every action and each status code;
// then random requests run under several window bases. A checker module
// predicts every response; this top drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module nor_flash_program_erase_model_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nfpe_pkg::*;

	// action code the block leaves unused: no effect, zero response
	localparam logic [2:0]  ACT_SPARE     = 3'd7;
	localparam logic [31:0] FLASH_SPAN    = 32'(FLASH_BYTES);
	// worst case: clearing pass, full erase and a dozen mass erases, each a
	// full array walk, plus every request paying both sides' longest idle
	localparam int          CYCLE_LIMIT   = 4_000_000;
	localparam int          SETTLE_CYCLES = 12;
	localparam int          PHASES        = 6;
	localparam int          PHASE_ITEMS   = 225;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// address[31:0], data[63:32], length[82:64], zero pad
	logic [S_TDATA_W-1:0] s_axis_tdata;
	// action[2:0]
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// read_data[31:0], status[33:32], zero pad
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	int                   mismatches;
	int                   outstanding;
	int unsigned          cycles = 0;
	logic [31:0]          win_base;   // base the stimulus aims at
	bit                   steady;     // no idling on either side while set
	int                   sent;

	always #1 clk = ~clk;

	nor_flash_program_erase_model dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	nfpe_access_checker access_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Watchdog: a hung handshake or a lost response ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("nor_flash_program_erase_model_tb: errors");
			$finish;
		end
	end

	// Response side: after each accepted response, hold tready low for a
	// randomly drawn hold (none in steady stretches). Driven at negedge,
	// sampled at posedge.
	initial begin : response_sink
		int hold;
		hold          = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				hold = steady ? 0 : $urandom_range(0, 9);
		end
	end

	// One request: random gap with tvalid low, then present and hold until
	// taken. A zero gap keeps tvalid high straight into the next request.
	// Every 40 requests the idling mode is redrawn for both sides.
	task automatic issue(input logic [2:0] act, input logic [31:0] addr,
	                     input logic [31:0] data, input logic [18:0] len);
		int gap;
		if (sent % 40 == 0) steady = ($urandom_range(0, 2) == 0);
		sent++;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= S_TDATA_W'({len, data, addr});
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drain: every request returns exactly one response, so once none is
	// pending the block is idle; a short pause covers the output register.
	task automatic settle();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write of window_base: setup cycle, then access until pready.
	task automatic apb_write(input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_WINDOW_BASE);
		pwdata  <= value;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		win_base  = value;
	endtask

	// Addresses mostly land in a few hot spots so writes get read back;
	// the rest sit on the window edges, the 2^32 wrap, or anywhere.
	function automatic logic [31:0] near_window();
		int          pick;
		logic [31:0] off;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			case ($urandom_range(0, 3))
			0: off = 32'd0;
			1: off = 32'(5 * PAGE_BYTES - 32);
			2: off = 32'(100 * PAGE_BYTES);
			default: off = FLASH_SPAN - 32'd64;
			endcase
			return win_base + off + 32'($urandom_range(0, 63));
		end
		if (pick < 75) return win_base - 32'($urandom_range(1, 4));
		if (pick < 88) return win_base + FLASH_SPAN - 32'd4 + 32'($urandom_range(0, 7));
		if (pick < 91) return 32'hFFFF_FFFC + 32'($urandom_range(0, 3));
		if (pick < 94) return 32'($urandom_range(0, 3));
		return $urandom;
	endfunction

	// Random request mix: reads, writes and word programs dominate; erases
	// stay small (large lengths go to random addresses, nearly always out of
	// range); mass erase is rare since it costs a full array walk.
	task automatic random_item();
		int          pick;
		int          spot;
		logic [2:0]  act;
		logic [31:0] a;
		logic [31:0] d;
		logic [18:0] n;
		pick = $urandom_range(0, 999);
		a    = near_window();
		// OR of two draws keeps most bits set so the image does not drain to 0
		d    = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom | $urandom);
		n    = '0;
		if (pick < 170) begin
			act = ACT_RD_BYTE;
		end else if (pick < 350) begin
			act = ACT_RD_WORD;
		end else if (pick < 480) begin
			act = ACT_WR_BYTE;
		end else if (pick < 620) begin
			act = ACT_WR_WORD;
		end else if (pick < 780) begin
			act  = ACT_PROG_WORD;
			spot = $urandom_range(0, 9);
			if (spot < 6) begin
				a[1:0] = 2'b00;
				n      = 19'd4;
			end else if (spot == 6) begin
				n = '0;
			end else begin
				n = 19'($urandom_range(0, FLASH_BYTES));
			end
		end else if (pick < 970) begin
			act  = ACT_ERASE;
			spot = $urandom_range(0, 9);
			if (spot < 6) begin
				n = 19'($urandom_range(1, 2 * PAGE_BYTES));
			end else if (spot == 6) begin
				n = '0;
			end else begin
				a = $urandom;
				n = 19'($urandom_range(0, FLASH_BYTES));
			end
		end else if (pick < 997) begin
			act = ACT_SPARE;
			n   = 19'($urandom_range(0, FLASH_BYTES));
		end else begin
			act = ACT_MASS_ERASE;
			n   = 19'($urandom_range(0, FLASH_BYTES));
		end
		issue(act, a, d, n);
	endtask

	initial begin : stimulus
		logic [31:0] b;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		win_base      = BASE_RESET;
		steady        = 1'b0;
		sent          = 0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// APB is open during the clearing pass; requests wait on tready.
		apb_write(BASE_RESET);
		b = BASE_RESET;

		// --- directed: byte access at both window edges ---
		issue(ACT_RD_BYTE, b, 32'h0, 19'd0);                  // erased: FF
		issue(ACT_RD_BYTE, b - 32'd1, 32'h0, 19'd0);          // just below
		issue(ACT_RD_BYTE, b + FLASH_SPAN, 32'h0, 19'd0);     // just above
		issue(ACT_WR_BYTE, b, 32'hFFFF_FFA5, 19'd0);
		issue(ACT_WR_BYTE, b, 32'h0000_000F, 19'd0);          // ANDs to 05
		issue(ACT_RD_BYTE, b, 32'h0, 19'd0);
		// --- word access, including words straddling either edge ---
		issue(ACT_WR_WORD, b + 32'd4, 32'h1234_5678, 19'd0);
		issue(ACT_RD_WORD, b + 32'd4, 32'h0, 19'd0);
		issue(ACT_RD_WORD, b - 32'd2, 32'h0, 19'd0);
		issue(ACT_WR_WORD, b + FLASH_SPAN - 32'd2, 32'h0, 19'd0);
		issue(ACT_RD_WORD, b + FLASH_SPAN - 32'd4, 32'h0, 19'd0);
		// --- word program: zero length, ok, misaligned, bad length, range ---
		issue(ACT_PROG_WORD, b + 32'd8, 32'h0, 19'd0);
		issue(ACT_PROG_WORD, b + 32'd8, 32'hFFFF_0000, 19'd4);
		issue(ACT_PROG_WORD, b + 32'd9, 32'h0, 19'd4);
		issue(ACT_PROG_WORD, b + 32'd8, 32'h0, 19'd8);
		issue(ACT_PROG_WORD, b + 32'd8, 32'h0, 19'd6);
		issue(ACT_PROG_WORD, b + FLASH_SPAN - 32'd2, 32'h0, 19'd4);
		issue(ACT_RD_WORD, b + 32'd8, 32'h0, 19'd0);
		// --- erase: zero length, one byte widened to a page, overrun ---
		issue(ACT_ERASE, b + 32'd1, 32'h0, 19'd0);
		issue(ACT_ERASE, b + 32'd1, 32'h0, 19'd1);
		issue(ACT_RD_WORD, b + 32'd4, 32'h0, 19'd0);
		issue(ACT_ERASE, b + FLASH_SPAN - 32'd1, 32'h0, 19'd2);
		issue(ACT_ERASE, b + FLASH_SPAN - 32'd1, 32'h0, 19'd1);
		// full-size erase, then mass erase and the unused code with junk fields
		issue(ACT_ERASE, b, 32'hFFFF_FFFF, 19'(FLASH_BYTES));
		issue(ACT_MASS_ERASE, $urandom, $urandom, 19'($urandom_range(0, FLASH_BYTES)));
		issue(ACT_SPARE, b, $urandom, 19'd4);

		// --- random phases, each under its own window base ---
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: b = BASE_RESET;
			1: b = 32'h0000_0000;                                // wrap reaches it
			2: b = 32'hFFFC_0000;                                // ends at the top
			3: b = 32'hFFFF_FFFF;                                // one byte left
			4: b = $urandom;
			default: b = 32'hFFFE_0000 + 32'($urandom_range(0, 255)); // clipped
			endcase
			settle();
			apb_write(b);
			repeat (PHASE_ITEMS) random_item();
		end

		settle();
		if (mismatches == 0) begin
			$display("nor_flash_program_erase_model_tb: clean");
		end else begin
			$display("nor_flash_program_erase_model_tb: errors");
		end
		$finish;
	end

endmodule
